[design/sfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and constants for the space filling curve point block
// ----------------------------------------------------------------------------
package sfc_pkg;
	localparam int MAX_DIM         = 16;
	localparam int MAX_LEVELS      = 16;
	localparam int X_FRACTION_BITS = 48;
	localparam int COORD_W         = 17;
	localparam int LANE_W          = $clog2(MAX_DIM);
	localparam int CNT_W           = $clog2(MAX_DIM + 1);
	localparam int LVL_W           = $clog2(MAX_LEVELS + 1);
	localparam int CFG_W           = 5;

	localparam logic REG_DIMENSION = 1'b0;
	localparam logic REG_DENSITY   = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t [MAX_DIM-1:0] acc;
		logic [CNT_W-1:0]     cnt;
	} sfc_vec_t;

	typedef struct packed {
		logic push;
	} sfc_qctl_t;
endpackage
`default_nettype wire

[design/sfc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_front
// accepts curve parameters and runs one curve level per cycle
// ----------------------------------------------------------------------------
module sfc_front import sfc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [X_FRACTION_BITS:0] x_value,
	input  wire logic [CFG_W-1:0]         dimension,
	input  wire logic [CFG_W-1:0]         density,
	output sfc_qctl_t                     qctl,
	input  wire logic                     q_full,
	output sfc_vec_t                      vec
);
	logic                         busy_q;
	logic [LVL_W-1:0]             lvl_q;
	logic [LVL_W-1:0]             m_q;
	logic [CNT_W-1:0]             n_q;
	logic                         one_q;
	logic [X_FRACTION_BITS-1:0]   frac_q;
	logic [MAX_DIM-1:0]           w_q;
	logic [LANE_W-1:0]            rot_q;
	coord_t [MAX_DIM-1:0]         acc_q;

	logic                         done, free, accept, step_en;
	logic [MAX_DIM-1:0]           b, lane_en, u_raw, v_raw, u_sw, v_sw, u_fin, w_next;
	logic [MAX_DIM-1:0]           cond0, cond1;
	logic                         all_zero, all_one, iq_neg, any_cond;
	logic [LANE_W-1:0]            node, n1, node_rm;
	logic                         bprev, above_ones, above_zeros;
	coord_t                       step;
	coord_t [MAX_DIM-1:0]         acc_next;
	logic [CNT_W-1:0]             n_sat;
	logic [LVL_W-1:0]             m_sat;

	assign n_sat = (dimension > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dimension);
	assign m_sat = (density > CFG_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : LVL_W'(density);

	assign done    = busy_q && (lvl_q == m_q);
	assign step_en = busy_q && (lvl_q != m_q);
	assign free    = !busy_q || (done && (!q_full || n_q == '0));
	assign full    = !free;
	assign accept  = push && free;

	assign qctl.push = done && !q_full && (n_q != '0);
	assign vec.acc   = acc_q;
	assign vec.cnt   = n_q;

	// subcube digit and sign vectors for the current level
	always_comb begin
		n1 = LANE_W'(n_q - CNT_W'(1));
		for (int i = 0; i < MAX_DIM; i++) begin
			lane_en[i] = (CNT_W'(i) < n_q);
			b[i]       = one_q | frac_q[X_FRACTION_BITS-1-i];
		end
		all_zero = ((b & lane_en) == '0);
		all_one  = ((b | ~lane_en) == '1);
		for (int i = 0; i < MAX_DIM; i++) begin
			above_ones  = 1'b1;
			above_zeros = 1'b1;
			for (int k = 0; k < MAX_DIM; k++) begin
				if (k > i && lane_en[k]) begin
					above_ones  = above_ones & b[k];
					above_zeros = above_zeros & ~b[k];
				end
			end
			cond0[i] = lane_en[i] && (LANE_W'(i) != n1) && !b[i] && above_ones;
			cond1[i] = lane_en[i] && (LANE_W'(i) != n1) && b[i] && above_zeros;
		end
		node     = '0;
		iq_neg   = 1'b0;
		any_cond = 1'b0;
		for (int i = 0; i < MAX_DIM; i++) begin
			if (cond0[i] || cond1[i]) begin
				node     = LANE_W'(i);
				iq_neg   = cond1[i];
				any_cond = 1'b1;
			end
		end
		// a set bit means the sign is negative
		for (int i = 0; i < MAX_DIM; i++) begin
			bprev    = (i == 0) ? 1'b0 : b[(i == 0) ? 0 : i-1];
			u_raw[i] = ~(b[i] ^ bprev);
		end
		v_raw = u_raw;
		if (all_zero) begin
			u_raw = '1;
			v_raw = '1;
			node  = n1;
		end else if (all_one) begin
			u_raw     = '1;
			v_raw     = '1;
			u_raw[0]  = 1'b0;
			v_raw[0]  = 1'b0;
			v_raw[n1] = 1'b0;
			node      = n1;
		end else begin
			v_raw[node] = v_raw[node] ^ (iq_neg & any_cond);
			v_raw[n1]   = ~v_raw[n1];
		end
		u_sw        = u_raw;
		v_sw        = v_raw;
		u_sw[0]     = u_raw[rot_q];
		u_sw[rot_q] = u_raw[0];
		v_sw[0]     = v_raw[rot_q];
		v_sw[rot_q] = v_raw[0];
		if (node == '0)
			node_rm = rot_q;
		else if (node == rot_q)
			node_rm = '0;
		else
			node_rm = node;
		u_fin  = u_sw ^ w_q;
		w_next = w_q ^ ~v_sw;
		step   = COORD_W'(1) << (4'd15 - lvl_q[3:0]);
		for (int i = 0; i < MAX_DIM; i++)
			acc_next[i] = u_fin[i] ? acc_q[i] - step : acc_q[i] + step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lvl_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			lvl_q  <= '0;
		end else if (done && free) begin
			busy_q <= 1'b0;
		end else if (step_en) begin
			lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_q    <= m_sat;
			n_q    <= n_sat;
			one_q  <= x_value[X_FRACTION_BITS];
			frac_q <= x_value[X_FRACTION_BITS] ? '0 : x_value[X_FRACTION_BITS-1:0];
			w_q    <= '0;
			rot_q  <= '0;
			acc_q  <= '0;
		end else if (step_en) begin
			frac_q <= frac_q << n_q;
			w_q    <= w_next;
			rot_q  <= node_rm;
			acc_q  <= acc_next;
		end
	end

`ifndef NO_ASSERTIONS
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> lvl_q <= m_q) else $error("level past density");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> !q_full) else $error("push into full queue");
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !accept |=> lvl_q == $past(lvl_q) + LVL_W'(1)) else $error("level stuck");
`endif
endmodule
`default_nettype wire

[design/sfc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_queue
// two entry queue of finished coordinate vectors
// ----------------------------------------------------------------------------
module sfc_queue import sfc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  sfc_qctl_t qctl,
	output logic      q_full,
	input  sfc_vec_t  wr_vec,
	output logic      q_valid,
	input  wire logic q_pop,
	output sfc_vec_t  rd_vec
);
	sfc_vec_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign rd_vec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qctl.push)
			mem_q[wr_ptr_q] <= wr_vec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (qctl.push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(qctl.push) - 2'(q_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q) else $error("ptr mismatch");
`endif
endmodule
`default_nettype wire

[design/sfc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_back
// walks a coordinate vector and emits one coordinate per transfer
// ----------------------------------------------------------------------------
module sfc_back import sfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_pop,
	input  sfc_vec_t         rd_vec,
	output logic             empty,
	input  wire logic        pop,
	output logic [LANE_W-1:0] coord_index,
	output coord_t           coord_value,
	output logic             last
);
	logic              ovalid_q;
	logic [LANE_W-1:0] idx_q;
	logic              load, is_last;

	assign load    = q_valid && (!ovalid_q || pop);
	assign is_last = (CNT_W'(idx_q) == rd_vec.cnt - CNT_W'(1));
	assign q_pop   = load && is_last;
	assign empty   = !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load)
				ovalid_q <= 1'b1;
			else if (pop)
				ovalid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? '0 : idx_q + LANE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coord_index <= idx_q;
			coord_value <= rd_vec.acc[idx_q];
			last        <= is_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> CNT_W'(idx_q) < rd_vec.cnt) else $error("lane index past count");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> idx_q == '0) else $error("index not rewound");
`endif
endmodule
`default_nettype wire

[design/space_filling_curve_point_top.sv]
`default_nettype none
// the front runs one curve level per cycle, density levels (16 at most), then hands the
// vector to the queue; it takes a new item only once the previous one has left the loop
// the back emits dimension results per item, one per cycle while pop is held, behind a two entry queue
// reset: arst_n clears control state; dimension resets to 2, density to 10
// ----------------------------------------------------------------------------
// space_filling_curve_point_top
// maps a curve parameter to the coordinates of a point on the evolvent
// ----------------------------------------------------------------------------
module space_filling_curve_point_top import sfc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic                     wr_index,
	input  wire logic [CFG_W-1:0]         wr_data,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [X_FRACTION_BITS:0] x_value,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [LANE_W-1:0]             coord_index,
	output coord_t                        coord_value,
	output logic                          last
);
	logic [CFG_W-1:0] dimension_q, density_q;
	sfc_qctl_t        qctl;
	sfc_vec_t         wr_vec, rd_vec;
	logic             q_full, q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= CFG_W'(2);
			density_q   <= CFG_W'(10);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DIMENSION: dimension_q <= wr_data;
				REG_DENSITY:   density_q   <= wr_data;
				default: ;
			endcase
		end
	end

	sfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.x_value   (x_value),
		.dimension (dimension_q),
		.density   (density_q),
		.qctl      (qctl),
		.q_full    (q_full),
		.vec       (wr_vec)
	);

	sfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.qctl    (qctl),
		.q_full  (q_full),
		.wr_vec  (wr_vec),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rd_vec  (rd_vec)
	);

	sfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.rd_vec      (rd_vec),
		.empty       (empty),
		.pop         (pop),
		.coord_index (coord_index),
		.coord_value (coord_value),
		.last        (last)
	);
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives curve parameters through the evolvent block under many dimension and
// density settings and checks every coordinate against a built-in predictor
// ----------------------------------------------------------------------------
module testbench;
	import sfc_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [X_FRACTION_BITS:0] X_ONE = 49'h1_0000_0000_0000;

	typedef struct {
		logic [LANE_W-1:0] index;
		coord_t            value;
		logic              last;
	} coord_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     wr_en;
	logic                     wr_index;
	logic [CFG_W-1:0]         wr_data;
	logic                     push;
	logic                     full;
	logic [X_FRACTION_BITS:0] x_value;
	logic                     empty;
	logic                     pop;
	logic [LANE_W-1:0]        coord_index;
	coord_t                   coord_value;
	logic                     last;

	logic [X_FRACTION_BITS:0] x_pending[$];
	coord_result_t            coords_expected[$];
	int                       dim_setting;
	int                       dens_setting;
	int                       errors;
	int                       cycles;
	bit                       quiet;
	int                       send_gap;
	int                       recv_stall;

	space_filling_curve_point_top u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full), .x_value(x_value), .empty(empty), .pop(pop),
		.coord_index(coord_index), .coord_value(coord_value), .last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// subcube number taken from n bits of the fraction at a given level
	function automatic logic [63:0] level_subcube(logic [47:0] frac, int level, int n);
		logic [63:0] digit;
		int          p;
		digit = '0;
		for (int b = 0; b < n; b++) begin
			p = level * n + b;
			digit = {digit[62:0], (p < X_FRACTION_BITS) ? frac[X_FRACTION_BITS-1-p] : 1'b0};
		end
		return digit;
	endfunction

	// per-axis signs and turn node of one subcube
	function automatic int turn_node(logic [63:0] sub, ref int u[MAX_DIM], ref int v[MAX_DIM],
	                                 input int n);
		int          node;
		int          iq;
		int          prev;
		int          cur;
		logic [63:0] rest;
		logic [63:0] half;
		node = 0;
		if (sub == 0 || sub == (64'd1 << n) - 1) begin
			for (int i = 0; i < n; i++) begin
				u[i] = -1;
				v[i] = -1;
			end
			if (sub != 0) begin
				u[0] = 1;
				v[0] = 1;
				v[n-1] = 1;
			end
			return n - 1;
		end
		iq = 1;
		prev = -1;
		rest = sub;
		for (int i = 0; i < n; i++) begin
			half = 64'd1 << (n - 1 - i);
			if (rest < half) begin
				cur = -1;
				if (rest == half - 1 && rest != 0) begin
					node = i;
					iq = 1;
				end
			end else begin
				if (rest == half && rest != 1) begin
					node = i;
					iq = -1;
				end
				rest = rest - half;
				cur = 1;
			end
			u[i] = -prev * cur;
			v[i] = -prev * cur;
			prev = cur;
		end
		v[node] = v[node] * iq;
		v[n-1] = -v[n-1];
		return node;
	endfunction

	function automatic void predict_point(logic [X_FRACTION_BITS:0] x);
		int            n;
		int            m;
		int            u[MAX_DIM];
		int            v[MAX_DIM];
		int            w[MAX_DIM];
		longint        acc[MAX_DIM];
		bit            is_one;
		logic [47:0]   frac;
		int            rot;
		int            node;
		int            t;
		longint        step;
		logic [63:0]   sub;
		coord_result_t r;
		n = dim_setting > MAX_DIM ? MAX_DIM : dim_setting;
		m = dens_setting > MAX_LEVELS ? MAX_LEVELS : dens_setting;
		if (n == 0)
			return;
		is_one = x >= X_ONE;
		frac = is_one ? '0 : x[47:0];
		rot = 0;
		for (int i = 0; i < n; i++) begin
			u[i] = 0;
			v[i] = 0;
			w[i] = 1;
			acc[i] = 0;
		end
		for (int j = 0; j < m; j++) begin
			sub = is_one ? (64'd1 << n) - 1 : level_subcube(frac, j, n);
			node = turn_node(sub, u, v, n);
			step = longint'(1) << (31 - j);
			t = u[0]; u[0] = u[rot]; u[rot] = t;
			t = v[0]; v[0] = v[rot]; v[rot] = t;
			if (node == 0)
				node = rot;
			else if (node == rot)
				node = 0;
			rot = node;
			for (int i = 0; i < n; i++) begin
				u[i] = u[i] * w[i];
				w[i] = w[i] * -v[i];
				acc[i] = acc[i] + (u[i] > 0 ? step : -step);
			end
		end
		for (int i = 0; i < n; i++) begin
			r.index = i[LANE_W-1:0];
			r.value = coord_t'(acc[i] >>> 16);
			r.last = (i == n - 1);
			coords_expected.push_back(r);
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			x_value <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full)
				predict_point(x_value);
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					push <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 15);
					push <= 1'b0;
				end else if (x_pending.size() > 0) begin
					push <= 1'b1;
					x_value <= x_pending.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (pop && !empty) begin
				if (coords_expected.size() == 0) begin
					$display("%0t: unexpected result index %0d value %0d", $time,
					         coord_index, coord_value);
					errors++;
				end else begin
					coord_result_t e;
					e = coords_expected.pop_front();
					if (coord_index !== e.index) begin
						$display("%0t: coord_index expected %0d actual %0d", $time,
						         e.index, coord_index);
						errors++;
					end
					if (coord_value !== e.value) begin
						$display("%0t: coord_value expected %0d actual %0d", $time,
						         e.value, coord_value);
						errors++;
					end
					if (last !== e.last) begin
						$display("%0t: last expected %0b actual %0b", $time, e.last, last);
						errors++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_stall <= $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_DIMENSION)
			dim_setting = value;
		else
			dens_setting = value;
	endtask

	task automatic drain;
		while (x_pending.size() > 0 || push || coords_expected.size() > 0)
			@(posedge clk);
		// an item with dimension zero may still be in the level loop
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [X_FRACTION_BITS:0] random_x();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: return X_ONE;
			1: return X_ONE | r[47:0];
			2: return X_ONE - 1 - r[5:0];
			3: return {1'b0, r[47:40], 40'd0};
			default: return {1'b0, r[47:0]};
		endcase
	endfunction

	initial begin
		int phase_dim[12] = '{1, 16, 31, 0, 3, 4, 5, 8, 16, 7, 2, 1};
		int phase_dens[12] = '{1, 16, 31, 5, 0, 7, 3, 12, 2, 16, 10, 31};
		logic [X_FRACTION_BITS:0] directed[14] = '{
			49'd0, X_ONE, X_ONE - 1, {49{1'b1}}, X_ONE + 1,
			49'h0_AAAA_AAAA_AAAA, 49'h0_5555_5555_5555, 49'h0_C000_0000_0000,
			49'h0_4000_0000_0000, 49'h0_8000_0000_0000, 49'h0_3FFF_FFFF_FFFF,
			49'h0_0000_0000_0001, 49'h0_9249_2492_4924, 49'h0_FFF0_0000_0000
		};
		errors = 0;
		cycles = 0;
		quiet = 0;
		dim_setting = 2;
		dens_setting = 10;
		wr_en = 1'b0;
		wr_index = REG_DIMENSION;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings first, with the edge values of x
		foreach (directed[k])
			x_pending.push_back(directed[k]);
		drain();

		foreach (phase_dim[p]) begin
			write_reg(REG_DIMENSION, phase_dim[p]);
			write_reg(REG_DENSITY, phase_dens[p]);
			if (p == 11)
				quiet = 1;
			if (p < 3)
				foreach (directed[k])
					x_pending.push_back(directed[k]);
			repeat (38) x_pending.push_back(random_x());
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
